// File: sv/arpc_pkg.sv
// Package for the ARP cache and responder.
// Holds sizes, protocol codes, item structs and the controller/datapath link types.
// No dependencies.
package arpc_pkg;

  localparam int unsigned Entries   = 8;
  localparam int unsigned StampBits = 32;
  localparam int unsigned TickBits  = (StampBits < 32) ? StampBits : 32;
  localparam int unsigned IdxBits   = $clog2(Entries);

  localparam logic [15:0] HwEthernet = 16'h0001;
  localparam logic [15:0] ProtoIpv4  = 16'h0800;
  localparam logic [15:0] OpRequest  = 16'd1;
  localparam logic [15:0] OpReply    = 16'd2;

  localparam logic [1:0]  OutOpNone    = 2'd0;
  localparam logic [1:0]  OutOpRequest = 2'd1;
  localparam logic [1:0]  OutOpReply   = 2'd2;

  localparam logic [47:0] MacBroadcast = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    CmdArp     = 2'd0,
    CmdResolve = 2'd1,
    CmdTick    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KindHit     = 2'd0,
    KindReply   = 2'd1,
    KindRequest = 2'd2
  } kind_e;

  typedef enum logic {
    RegOwnIp  = 1'b0,
    RegOwnMac = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] tgt_ip;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] resolved_mac;
    logic [47:0] dest_mac;
    logic [1:0]  out_opcode;
    logic [31:0] out_sender_ip;
    logic [47:0] out_target_mac;
    logic [31:0] out_tgt_ip;
  } out_item_t;

  typedef struct packed {
    logic item_load;
    logic scan_clear;
    logic scan_issue;
    logic entry_write;
    logic tick;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_reply_pkt;
    logic is_req_hit;
    logic is_resolve;
    logic is_tick;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

// File: sv/arpc_ctrl.sv
// Controller of the ARP cache and responder: sequences decode, cache scan,
// cache update and result load. Depends on arpc_pkg.
module arpc_ctrl import arpc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StDecode = 6'b000010,
    StScan   = 6'b000100,
    StFinish = 6'b001000,
    StUpdate = 6'b010000,
    StEmit   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = StDecode;
        end
      end
      StDecode: begin
        if (sts_i.is_reply_pkt || sts_i.is_resolve) begin
          cmd_o.scan_clear = 1'b1;
          state_d          = StScan;
        end else if (sts_i.is_req_hit) begin
          state_d = StEmit;
        end else begin
          cmd_o.tick = sts_i.is_tick;
          state_d    = StIdle;
        end
      end
      StScan: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StFinish;
        end
      end
      // last entry is compared during this cycle
      StFinish: begin
        state_d = sts_i.is_resolve ? StEmit : StUpdate;
      end
      StUpdate: begin
        cmd_o.entry_write = 1'b1;
        state_d           = StIdle;
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/arpc_dp.sv
// Datapath of the ARP cache and responder: item and configuration registers,
// cache storage, scan accumulators, tick counter and output register. Depends on arpc_pkg.
module arpc_dp import arpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_data_i,
  input  logic        cfg_write_i,
  input  logic        cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  in_item_t            item_q;
  logic [31:0]         own_ip_q;
  logic [TickBits-1:0] tick_q;

  // cache storage
  logic [Entries-1:0]  valid_q;
  logic [31:0]         ip_mem    [Entries];
  logic [47:0]         mac_mem   [Entries];
  logic [TickBits-1:0] stamp_mem [Entries];

  // scan read stage
  logic [IdxBits-1:0]  rd_idx_q;
  logic [IdxBits-1:0]  cmp_idx_q;
  logic                rd_vld_q;
  logic                rd_valid_q;
  logic [31:0]         rd_ip_q;
  logic [47:0]         rd_mac_q;
  logic [TickBits-1:0] rd_stamp_q;

  // scan accumulators
  logic                hit_q;
  logic [IdxBits-1:0]  hit_idx_q;
  logic [47:0]         hit_mac_q;
  logic                free_q;
  logic [IdxBits-1:0]  free_idx_q;
  logic [IdxBits-1:0]  old_idx_q;
  logic [TickBits-1:0] old_stamp_q;

  logic                out_valid_q;
  out_item_t           out_q, out_d;

  logic                types_ok;
  logic [31:0]         key_ip;
  logic [IdxBits-1:0]  wr_idx;

  assign types_ok = (item_q.cmd == CmdArp) && (item_q.hw_type == HwEthernet)
                    && (item_q.proto_type == ProtoIpv4);
  assign key_ip   = (item_q.cmd == CmdResolve) ? item_q.tgt_ip : item_q.sender_ip;
  assign wr_idx   = hit_q ? hit_idx_q : (free_q ? free_idx_q : old_idx_q);

  assign sts_o.is_reply_pkt = types_ok && (item_q.opcode == OpReply);
  assign sts_o.is_req_hit   = types_ok && (item_q.opcode == OpRequest) && (own_ip_q != '0)
                              && (item_q.tgt_ip == own_ip_q);
  assign sts_o.is_resolve   = (item_q.cmd == CmdResolve);
  assign sts_o.is_tick      = (item_q.cmd == CmdTick);
  assign sts_o.scan_last    = (rd_idx_q == IdxBits'(Entries - 1));
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  // own MAC is not stored here: writes to it change nothing, and it is not part of the result item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
    end else if (cfg_write_i && (cfg_index_i == RegOwnIp)) begin
      own_ip_q <= cfg_data_i[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      item_q <= in_data_i;
    end
  end

  // saturate at all ones
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (cmd_i.tick && (tick_q != '1)) begin
      tick_q <= tick_q + TickBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.entry_write) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.entry_write) begin
      ip_mem[wr_idx]    <= item_q.sender_ip;
      mac_mem[wr_idx]   <= item_q.sender_mac;
      stamp_mem[wr_idx] <= tick_q;
    end
    if (cmd_i.scan_issue) begin
      rd_ip_q    <= ip_mem[rd_idx_q];
      rd_mac_q   <= mac_mem[rd_idx_q];
      rd_stamp_q <= stamp_mem[rd_idx_q];
      rd_valid_q <= valid_q[rd_idx_q];
      cmp_idx_q  <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_issue;
      if (cmd_i.scan_clear) begin
        rd_idx_q <= '0;
        hit_q    <= 1'b0;
        free_q   <= 1'b0;
      end else begin
        if (cmd_i.scan_issue) begin
          rd_idx_q <= rd_idx_q + IdxBits'(1);
        end
        if (rd_vld_q) begin
          // keep the lowest matching index
          if (rd_valid_q && (rd_ip_q == key_ip) && !hit_q) begin
            hit_q <= 1'b1;
          end
          if (!rd_valid_q && !free_q) begin
            free_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && !cmd_i.scan_clear) begin
      if (rd_valid_q && (rd_ip_q == key_ip) && !hit_q) begin
        hit_idx_q <= cmp_idx_q;
        hit_mac_q <= rd_mac_q;
      end
      if (!rd_valid_q && !free_q) begin
        free_idx_q <= cmp_idx_q;
      end
      // strict compare keeps the lowest index on equal stamps
      if ((cmp_idx_q == '0) || (rd_stamp_q < old_stamp_q)) begin
        old_idx_q   <= cmp_idx_q;
        old_stamp_q <= rd_stamp_q;
      end
    end
  end

  always_comb begin
    out_d = '0;
    if (item_q.cmd == CmdResolve) begin
      if (hit_q) begin
        out_d.kind         = KindHit;
        out_d.resolved_mac = hit_mac_q;
      end else begin
        out_d.kind          = KindRequest;
        out_d.dest_mac      = MacBroadcast;
        out_d.out_opcode    = OutOpRequest;
        out_d.out_sender_ip = own_ip_q;
        out_d.out_tgt_ip    = item_q.tgt_ip;
      end
    end else begin
      out_d.kind           = KindReply;
      out_d.dest_mac       = item_q.sender_mac;
      out_d.out_opcode     = OutOpReply;
      out_d.out_sender_ip  = own_ip_q;
      out_d.out_target_mac = item_q.sender_mac;
      out_d.out_tgt_ip     = item_q.sender_ip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/arp_cache_responder_top.sv
// ARP cache and responder, top level. An item is a received ARP packet, a resolve
// lookup or a tick. Ticks and dropped packets pass through decode only; a matching
// request goes to the emit state, which waits for a free output register; replies
// and resolves scan the cache one entry per cycle through its registered read port,
// then replies update the cache and resolves emit. The output register lets a new
// item be accepted while a result still waits. Configuration writes are always ready.
// Depends on arpc_pkg, arpc_ctrl and arpc_dp.
module arp_cache_responder_top import arpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  assign cfg_ready_o = 1'b1;

  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  arpc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_write_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
